FILE: hdl/lqms_pkg.sv
// Shared types, constants and the link classification for the link quality mode selector.
// No dependencies; used by lqms_core and link_quality_mode_selector.
`timescale 1ns / 1ps

package lqms_pkg;

    // Default sizes for the top-level parameters
    localparam int TIME_BITS_DEF = 48;
    localparam int RUN_BITS_DEF  = 4;

    // Fixed field widths
    localparam int NOW_W      = 48;
    localparam int MS_W       = 20;
    localparam int THR_W      = 4;
    localparam int RUNG_W     = 2;
    localparam int SIG_W      = 8;
    localparam int LOSS_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    typedef logic [RUNG_W-1:0]    rung_t;
    typedef logic [MS_W-1:0]      ms_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam rung_t RUNG_BEST  = 2'd0;
    localparam rung_t RUNG_NL48  = 2'd1;
    localparam rung_t RUNG_HQ96  = 2'd2;
    localparam rung_t RUNG_WORST = 2'd3;

    // Request kinds carried on tuser
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_START  = 1'b1;

    // Register indexes
    localparam cfg_idx_t REG_HEADROOM_OK    = 3'd0;
    localparam cfg_idx_t REG_DOWNGRADE_REPS = 3'd1;
    localparam cfg_idx_t REG_UPGRADE_REPS   = 3'd2;
    localparam cfg_idx_t REG_UPGRADE_HOLD   = 3'd3;
    localparam cfg_idx_t REG_PROBE_BASE     = 3'd4;
    localparam cfg_idx_t REG_PROBE_LIMIT    = 3'd5;
    localparam cfg_idx_t REG_PROBE_FORGET   = 3'd6;

    // Register reset values
    localparam logic             HEADROOM_RST     = 1'b1;
    localparam logic [THR_W-1:0] DOWNGRADE_RST    = 4'd2;
    localparam logic [THR_W-1:0] UPGRADE_RST      = 4'd3;
    localparam ms_t              UPGRADE_HOLD_RST = 20'd2000;
    localparam ms_t              PROBE_BASE_RST   = 20'd2000;
    localparam ms_t              PROBE_LIMIT_RST  = 20'd32000;
    localparam ms_t              PROBE_FORGET_RST = 20'd60000;

    // Classification thresholds (signal in dBm, loss in hundredths of a percent)
    localparam logic signed [SIG_W-1:0] SIG_RUNG0 = -8'sd65;
    localparam logic signed [SIG_W-1:0] SIG_RUNG1 = -8'sd75;
    localparam logic signed [SIG_W-1:0] SIG_RUNG2 = -8'sd80;
    localparam logic [LOSS_W-1:0] LOSS_RUNG0 = 14'd100;
    localparam logic [LOSS_W-1:0] LOSS_RUNG1 = 14'd300;
    localparam logic [LOSS_W-1:0] LOSS_RUNG2 = 14'd800;

    typedef struct packed {
        logic             headroom_ok;
        logic [THR_W-1:0] downgrade_reports;
        logic [THR_W-1:0] upgrade_reports;
        ms_t              upgrade_hold_ms;
        ms_t              probe_base_ms;
        ms_t              probe_limit_ms;
        ms_t              probe_forget_ms;
    } cfg_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [SIG_W-1:0]  signal_dbm;
        logic [LOSS_W-1:0]        loss_centipct;
        logic                     congested;
        logic [NOW_W-1:0]         now_ms;
        rung_t                    start_rung;
    } item_t;

    typedef struct packed {
        rung_t rung;
        logic  switched;
        logic  mode_hq;
        logic  rate_96k;
    } res_t;

    function automatic rung_t classify(logic signed [SIG_W-1:0] sig,
                                       logic [LOSS_W-1:0] loss);
        rung_t r;
        if (sig > SIG_RUNG0 && loss < LOSS_RUNG0)
            r = RUNG_BEST;
        else if (sig > SIG_RUNG1 && loss < LOSS_RUNG1)
            r = RUNG_NL48;
        else if (sig > SIG_RUNG2 && loss < LOSS_RUNG2)
            r = RUNG_HQ96;
        else
            r = RUNG_WORST;
        return r;
    endfunction

endpackage

FILE: hdl/lqms_core.sv
// Rung decision state and its single-pass next-state logic.
// Depends on lqms_pkg; instantiated by link_quality_mode_selector.
`timescale 1ns / 1ps

module lqms_core #(
    parameter int TIME_BITS = lqms_pkg::TIME_BITS_DEF,
    parameter int RUN_BITS  = lqms_pkg::RUN_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  lqms_pkg::item_t item,
    input  lqms_pkg::cfg_t  cfg,
    output lqms_pkg::res_t  res
);

    localparam int NOW_EXT_W = (TIME_BITS > lqms_pkg::NOW_W) ? TIME_BITS : lqms_pkg::NOW_W;
    localparam int CMP_W     = (RUN_BITS > lqms_pkg::THR_W) ? RUN_BITS : lqms_pkg::THR_W;

    typedef logic [TIME_BITS-1:0] tstamp_t;
    typedef logic [RUN_BITS-1:0]  run_t;

    lqms_pkg::rung_t cur_rung_reg,   cur_rung_next;
    lqms_pkg::rung_t floor_rung_reg, floor_rung_next;
    run_t            good_run_reg,   good_run_next;
    run_t            bad_run_reg,    bad_run_next;
    tstamp_t         last_switch_reg, last_switch_next;
    logic            ever_sw_reg,    ever_sw_next;
    tstamp_t         relax_time_reg, relax_time_next;
    lqms_pkg::ms_t   probe_ivl_reg,  probe_ivl_next;
    tstamp_t         last_cong_reg,  last_cong_next;

    logic [NOW_EXT_W-1:0] now_ext;
    tstamp_t              now_t;
    tstamp_t              since_cong;
    tstamp_t              since_switch;
    logic                 forget;
    logic                 relax;
    logic                 cong;
    logic                 held;
    logic                 switched;
    lqms_pkg::ms_t        ivl_fresh;
    lqms_pkg::ms_t        ivl_rep;
    logic [lqms_pkg::MS_W:0] ivl_dbl;
    lqms_pkg::rung_t      worse;
    lqms_pkg::rung_t      floor_rep;
    lqms_pkg::rung_t      target_cls;
    lqms_pkg::rung_t      target;
    run_t                 good_inc;
    run_t                 bad_inc;

    always_comb
    begin
        now_ext      = NOW_EXT_W'(item.now_ms);
        now_t        = now_ext[TIME_BITS-1:0];
        cong         = item.congested;
        since_cong   = now_t - last_cong_reg;
        since_switch = now_t - last_switch_reg;

        // probe interval falls back to base after a long clean spell
        forget = (last_cong_reg != '0) && !cong
                 && (since_cong >= TIME_BITS'(cfg.probe_forget_ms));
        ivl_fresh = forget ? cfg.probe_base_ms : probe_ivl_reg;

        relax = (floor_rung_reg != lqms_pkg::RUNG_BEST) && (now_t >= relax_time_reg)
                && cfg.headroom_ok && !cong;

        ivl_dbl = {ivl_fresh, 1'b0};
        worse   = (cur_rung_reg == lqms_pkg::RUNG_WORST) ? lqms_pkg::RUNG_WORST
                                                          : cur_rung_reg + 2'd1;

        if (cong)
        begin
            floor_rep = (worse > floor_rung_reg) ? worse : floor_rung_reg;
            ivl_rep   = (ivl_dbl > {1'b0, cfg.probe_limit_ms}) ? cfg.probe_limit_ms
                                                                : ivl_dbl[lqms_pkg::MS_W-1:0];
        end
        else
        begin
            floor_rep = relax ? floor_rung_reg - 2'd1 : floor_rung_reg;
            ivl_rep   = ivl_fresh;
        end

        target_cls = lqms_pkg::classify(item.signal_dbm, item.loss_centipct);
        target     = (target_cls < floor_rep) ? floor_rep : target_cls;

        good_inc = (good_run_reg == '1) ? good_run_reg : good_run_reg + run_t'(1);
        bad_inc  = (bad_run_reg == '1) ? bad_run_reg : bad_run_reg + run_t'(1);
        held     = !ever_sw_reg || (since_switch >= TIME_BITS'(cfg.upgrade_hold_ms));

        // report path defaults
        cur_rung_next    = cur_rung_reg;
        floor_rung_next  = floor_rep;
        probe_ivl_next   = ivl_rep;
        relax_time_next  = (cong || relax) ? now_t + TIME_BITS'(ivl_rep) : relax_time_reg;
        last_cong_next   = cong ? now_t : last_cong_reg;
        last_switch_next = last_switch_reg;
        ever_sw_next     = ever_sw_reg;
        switched         = 1'b0;

        if (target > cur_rung_reg)
        begin
            good_run_next = '0;
            bad_run_next  = bad_inc;
            switched      = cong || (CMP_W'(bad_inc) >= CMP_W'(cfg.downgrade_reports));
        end
        else if (target < cur_rung_reg)
        begin
            bad_run_next  = '0;
            good_run_next = good_inc;
            switched      = (CMP_W'(good_inc) >= CMP_W'(cfg.upgrade_reports)) && held;
        end
        else
        begin
            good_run_next = '0;
            bad_run_next  = '0;
        end

        if (switched)
        begin
            cur_rung_next    = target;
            good_run_next    = '0;
            bad_run_next     = '0;
            last_switch_next = now_t;
            ever_sw_next     = 1'b1;
        end

        // start request: seed rung, run counters untouched
        if (item.cmd == lqms_pkg::CMD_START)
        begin
            switched         = 1'b0;
            cur_rung_next    = item.start_rung;
            floor_rung_next  = item.start_rung;
            probe_ivl_next   = cfg.probe_base_ms;
            relax_time_next  = now_t + TIME_BITS'(cfg.probe_base_ms);
            last_switch_next = now_t;
            ever_sw_next     = 1'b1;
            last_cong_next   = last_cong_reg;
            good_run_next    = good_run_reg;
            bad_run_next     = bad_run_reg;
        end

        res.rung     = cur_rung_next;
        res.switched = switched;
        res.mode_hq  = (cur_rung_next >= lqms_pkg::RUNG_HQ96);
        res.rate_96k = (cur_rung_next == lqms_pkg::RUNG_BEST)
                       || (cur_rung_next == lqms_pkg::RUNG_HQ96);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_rung_reg    <= lqms_pkg::RUNG_BEST;
            floor_rung_reg  <= lqms_pkg::RUNG_BEST;
            good_run_reg    <= '0;
            bad_run_reg     <= '0;
            last_switch_reg <= '0;
            ever_sw_reg     <= 1'b0;
            relax_time_reg  <= '0;
            probe_ivl_reg   <= lqms_pkg::PROBE_BASE_RST;
            last_cong_reg   <= '0;
        end
        else if (step)
        begin
            cur_rung_reg    <= cur_rung_next;
            floor_rung_reg  <= floor_rung_next;
            good_run_reg    <= good_run_next;
            bad_run_reg     <= bad_run_next;
            last_switch_reg <= last_switch_next;
            ever_sw_reg     <= ever_sw_next;
            relax_time_reg  <= relax_time_next;
            probe_ivl_reg   <= probe_ivl_next;
            last_cong_reg   <= last_cong_next;
        end
    end

endmodule

FILE: hdl/link_quality_mode_selector.sv
// Top level of the link quality mode selector: stream ports, register bank, pipeline.
// Depends on lqms_pkg and lqms_core.
`timescale 1ns / 1ps

// Link quality mode selector
// Slave stream takes one request per beat: a link report (tuser low) or a
// start request (tuser high) that seeds the rung. Master stream returns exactly
// one result per request: rung, whether this report committed a switch, and the
// codec mode and sample rate of the rung.
// Pipeline: an input register, one pass of decision logic, an output register.
// A request moves from the input register through the decision logic into the
// output register; throughput is one request per cycle while m_tready is high.
// The decision state is updated as a request moves from the input register to
// the output register, so back-to-back requests see each other's updates.
// Receiver stall: the output register holds its result; the input register
// still takes one more request, then s_tready drops until m_tready returns.
// Reset (rst_n low, async): both stages empty, rung and floor at the best rung,
// counters clear, registers at their defaults. Config port: write-only, one register
// per cycle; the user applies writes only while idle; the block does not enforce it.

module link_quality_mode_selector #(
    parameter int TIME_BITS = lqms_pkg::TIME_BITS_DEF,
    parameter int RUN_BITS  = lqms_pkg::RUN_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] signal_dbm, [21:8] loss_centipct, [22] congested,
    // [70:23] now_ms, [72:71] start_rung, [79:73] zero
    input  logic [lqms_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] cmd
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] rung, [2] switched, [3] mode_hq, [4] rate_96k, [7:5] zero
    output logic [lqms_pkg::OUT_DATA_W-1:0]    m_tdata,
    // register writes
    input  logic                               cfg_we,
    input  logic [lqms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lqms_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lqms_pkg::cfg_t  cfg_reg;
    lqms_pkg::item_t in_item_reg;
    logic            in_valid_reg;
    lqms_pkg::res_t  out_res_reg;
    logic            out_valid_reg;
    lqms_pkg::res_t  res;
    logic            out_free;
    logic            step;

    // output stage can load when empty or draining this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.headroom_ok       <= lqms_pkg::HEADROOM_RST;
            cfg_reg.downgrade_reports <= lqms_pkg::DOWNGRADE_RST;
            cfg_reg.upgrade_reports   <= lqms_pkg::UPGRADE_RST;
            cfg_reg.upgrade_hold_ms   <= lqms_pkg::UPGRADE_HOLD_RST;
            cfg_reg.probe_base_ms     <= lqms_pkg::PROBE_BASE_RST;
            cfg_reg.probe_limit_ms    <= lqms_pkg::PROBE_LIMIT_RST;
            cfg_reg.probe_forget_ms   <= lqms_pkg::PROBE_FORGET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lqms_pkg::REG_HEADROOM_OK:    cfg_reg.headroom_ok       <= cfg_data[0];
                lqms_pkg::REG_DOWNGRADE_REPS: cfg_reg.downgrade_reports <= cfg_data[3:0];
                lqms_pkg::REG_UPGRADE_REPS:   cfg_reg.upgrade_reports   <= cfg_data[3:0];
                lqms_pkg::REG_UPGRADE_HOLD:   cfg_reg.upgrade_hold_ms   <= cfg_data;
                lqms_pkg::REG_PROBE_BASE:     cfg_reg.probe_base_ms     <= cfg_data;
                lqms_pkg::REG_PROBE_LIMIT:    cfg_reg.probe_limit_ms    <= cfg_data;
                lqms_pkg::REG_PROBE_FORGET:   cfg_reg.probe_forget_ms   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input stage payload: unpack the stream beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd           <= s_tuser;
            in_item_reg.signal_dbm    <= s_tdata[7:0];
            in_item_reg.loss_centipct <= s_tdata[21:8];
            in_item_reg.congested     <= s_tdata[22];
            in_item_reg.now_ms        <= s_tdata[70:23];
            in_item_reg.start_rung    <= s_tdata[72:71];
        end
    end

    lqms_core #(
        .TIME_BITS (TIME_BITS),
        .RUN_BITS  (RUN_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.rate_96k, out_res_reg.mode_hq,
                       out_res_reg.switched, out_res_reg.rung};

endmodule
